/* rtl/cht_pkg.sv */
// Package with shared constants and codes for the convex hull trick line store.
`timescale 1ns / 1ps
`default_nettype none
package cht_pkg;
  localparam int MaxLines       = 1024;
  localparam int SlopeWidth     = 32;
  localparam int InterceptWidth = 48;
  localparam int CoordWidth     = 32;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_WALK   = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
endpackage
`default_nettype wire

/* rtl/cht_mul.sv */
// Signed multiplier split over four 32x32 partial products.
`timescale 1ns / 1ps
`default_nettype none
module cht_mul (
  input  wire logic               clk,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic                    done,
  output logic signed [127:0]     product
);
  logic [63:0]  ua, ub;
  logic         neg;
  logic [1:0]   step;
  logic         busy;
  logic [127:0] acc;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] sh;

  always_comb begin
    pa = step[1] ? ua[63:32] : ua[31:0];
    pb = step[0] ? ub[63:32] : ub[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    sh = {64'd0, pp} << (7'(step[1] + step[0]) * 7'd32);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      ua   <= a[63] ? 64'(-a) : a;
      ub   <= b[63] ? 64'(-b) : b;
      neg  <= a[63] ^ b[63];
      acc  <= '0;
      step <= 2'd0;
      busy <= 1'b1;
    end else if (busy) begin
      acc  <= acc + sh;
      step <= step + 2'd1;
      if (step == 2'd3) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign product = neg ? -$signed(acc) : $signed(acc);
endmodule
`default_nettype wire

/* rtl/convex_hull_trick_line_store.sv */
// Top level of the convex hull trick line store.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps a lower (min_mode 1) or upper (min_mode 0) envelope of lines
// y = slope*x + intercept, added in monotonic slope order, in two synchronous
// memories with a registered read port. One item is worked at a time, and how
// long an item takes is set by how many lines it has to read and compare. Each
// memory read passes through a read state and a wait state, and the shared
// multiplier forms each product in steps: it loads the operands, accumulates
// the four partial products and hands over the result. An add to a store
// holding fewer than two lines only writes the new line, so the next item can
// be taken on the following cycle. Any other add to a store that is not full
// reads the last three lines and forms two wide products for a redundancy
// test, and each line it pops adds a write back plus another test while at
// least three lines remain. A walking query reads and compares a pair of
// lines per pointer step plus the final pair, and then loads the result
// register. A search query likewise reads and compares a pair per halving
// step, plus a final read, and then loads the result register. Results wait in
// an output register, and a new item is taken when that register is free.
// Queries on an empty store give status 1, an add to a full store status 2,
// both with a zero value and on the cycle after the item is taken. Operation
// three is dropped without a result.
module convex_hull_trick_line_store #(
  parameter int MAX_LINES       = cht_pkg::MaxLines,
  parameter int SLOPE_WIDTH     = cht_pkg::SlopeWidth,
  parameter int INTERCEPT_WIDTH = cht_pkg::InterceptWidth,
  parameter int COORD_WIDTH     = cht_pkg::CoordWidth
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  operation,
  input  wire logic signed [SLOPE_WIDTH-1:0]     slope,
  input  wire logic signed [INTERCEPT_WIDTH-1:0] intercept,
  input  wire logic signed [COORD_WIDTH-1:0]     query_x,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [63:0]               best_value,
  output logic [1:0]                       status,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_data
);
  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2,
                         S_MULW = 4'd4, S_EVAL = 4'd5, S_POPW = 4'd6,
                         S_OUT = 4'd7, S_CMP = 4'd8;

  logic signed [SLOPE_WIDTH-1:0]     slope_mem [MAX_LINES];
  logic signed [INTERCEPT_WIDTH-1:0] icpt_mem  [MAX_LINES];

  logic [3:0]    state;
  logic          min_mode;
  logic [CW-1:0] line_count;
  logic [AW-1:0] walk_pointer;
  logic [1:0]    op;
  logic signed [COORD_WIDTH-1:0] qx;
  logic [AW-1:0] lo, hi, mid;
  logic [1:0]    rd_idx;
  logic [1:0]    mul_idx;
  logic [AW-1:0] rd_addr;
  logic          rd_en, wr_en;
  logic [AW-1:0] wr_addr;
  logic signed [SLOPE_WIDTH-1:0]     wr_slope, rd_slope;
  logic signed [INTERCEPT_WIDTH-1:0] wr_icpt, rd_icpt;
  logic signed [63:0] m [3];
  logic signed [63:0] b [3];
  logic signed [127:0] pq [2];
  logic          mul_start, mul_done;
  logic signed [63:0] mul_a, mul_b;
  logic signed [127:0] mul_p;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slope_mem[wr_addr] <= wr_slope;
      icpt_mem[wr_addr]  <= wr_icpt;
    end
    if (rd_en) begin
      rd_slope <= slope_mem[rd_addr];
      rd_icpt  <= icpt_mem[rd_addr];
    end
  end

  cht_mul u_mul (
    .clk(clk), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(mul_p)
  );

  assign in_stall  = (state != S_IDLE) || out_valid;
  assign cfg_ready = 1'b1;

  logic accept;
  assign accept = in_valid && !in_stall;

  // Which line indexes to read, and what the multiplier is fed, per operation.
  always_comb begin
    rd_en   = (state == S_RD);
    rd_addr = '0;
    if (op == cht_pkg::OP_ADD) begin
      rd_addr = AW'(line_count - CW'(3) + CW'(rd_idx));
    end else if (op == cht_pkg::OP_WALK) begin
      rd_addr = walk_pointer + AW'(rd_idx);
    end else begin
      rd_addr = mid + AW'(rd_idx);
    end
    if (op == cht_pkg::OP_ADD) begin
      mul_a = (mul_idx == 2'd0) ? b[2] - b[0] : b[1] - b[0];
      mul_b = (mul_idx == 2'd0) ? m[0] - m[1] : m[0] - m[2];
    end else begin
      mul_a = m[mul_idx];
      mul_b = 64'(qx);
    end
  end

  logic redundant, nxt_better;
  logic signed [63:0] v0, v1;
  assign v0 = 64'(pq[0]) + b[0];
  assign v1 = 64'(pq[1]) + b[1];
  always_comb begin
    redundant  = min_mode ? (pq[0] <= pq[1]) : (pq[0] > pq[1]);
    nxt_better = min_mode ? (v1 < v0) : (v1 > v0);
  end

  always_ff @(posedge clk) begin
    wr_en     <= 1'b0;
    mul_start <= 1'b0;
    if (rst) begin
      state        <= S_IDLE;
      min_mode     <= 1'b1;
      line_count   <= '0;
      walk_pointer <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) min_mode <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op <= operation;
            qx <= query_x;
            if (operation == cht_pkg::OP_ADD) begin
              if (line_count >= CW'(MAX_LINES)) begin
                best_value <= '0; status <= cht_pkg::ST_FULL; out_valid <= 1'b1;
              end else begin
                wr_en    <= 1'b1;
                wr_addr  <= AW'(line_count);
                wr_slope <= slope;
                wr_icpt  <= intercept;
                line_count <= line_count + CW'(1);
                if (line_count >= CW'(2)) begin
                  rd_idx <= 2'd0; state <= S_RD;
                end
              end
            end else if (operation == cht_pkg::OP_WALK ||
                         operation == cht_pkg::OP_SEARCH) begin
              if (line_count == '0) begin
                best_value <= '0; status <= cht_pkg::ST_EMPTY; out_valid <= 1'b1;
              end else if (operation == cht_pkg::OP_WALK) begin
                if (CW'(walk_pointer) >= line_count)
                  walk_pointer <= AW'(line_count - CW'(1));
                state <= S_CMP;
              end else begin
                lo <= '0; hi <= AW'(line_count - CW'(1));
                state <= S_CMP;
              end
            end
          end
        end
        // Pick the pair of lines to compare next. Once the search has closed
        // in, the midpoint equals lo, so the last read gives the answer line.
        S_CMP: begin
          rd_idx <= 2'd0;
          state  <= S_RD;
          if (op == cht_pkg::OP_WALK) begin
            lo <= walk_pointer;
          end else begin
            mid <= AW'(({1'b0, lo} + {1'b0, hi}) >> 1);
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          m[rd_idx] <= 64'(rd_slope);
          b[rd_idx] <= 64'(rd_icpt);
          if (rd_idx == ((op == cht_pkg::OP_ADD) ? 2'd2 : 2'd1)) begin
            mul_idx <= 2'd0; mul_start <= 1'b1; state <= S_MULW;
          end else begin
            rd_idx <= rd_idx + 2'd1; state <= S_RD;
          end
        end
        S_MULW: begin
          if (mul_done) begin
            pq[mul_idx[0]] <= mul_p;
            if (mul_idx == 2'd0) begin
              mul_idx <= 2'd1; mul_start <= 1'b1;
            end else state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (op == cht_pkg::OP_ADD) begin
            if (redundant) begin
              wr_en    <= 1'b1;
              wr_addr  <= AW'(line_count - CW'(2));
              wr_slope <= SLOPE_WIDTH'(m[2]);
              wr_icpt  <= INTERCEPT_WIDTH'(b[2]);
              line_count <= line_count - CW'(1);
              state <= S_POPW;
            end else state <= S_IDLE;
          end else if (op == cht_pkg::OP_WALK) begin
            if (CW'(walk_pointer) + CW'(1) < line_count && nxt_better) begin
              walk_pointer <= walk_pointer + AW'(1);
              state <= S_CMP;
            end else begin
              best_value <= v0; status <= cht_pkg::ST_OK; state <= S_OUT;
            end
          end else begin
            if (lo < hi) begin
              if (nxt_better) lo <= mid + AW'(1); else hi <= mid;
              state <= S_CMP;
            end else begin
              best_value <= v0; status <= cht_pkg::ST_OK; state <= S_OUT;
            end
          end
        end
        S_POPW: begin
          rd_idx <= 2'd0;
          state  <= (line_count >= CW'(3)) ? S_RD : S_IDLE;
        end
        S_OUT: begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
